// File: rtl/scfe_pkg.sv
// Package for the source command frame encoder.
// Field widths, frame byte codes, command codes and the shared types.
// No dependencies.
package scfe_pkg;

  // Input field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 37;
  localparam int unsigned BYTE_W  = 8;

  // Decimal digits needed to hold any VALUE_W-bit binary number
  localparam int unsigned BIN_DIGITS = 12;

  // Parameter defaults
  localparam int unsigned BCD_DIGITS_DEF   = 6;
  localparam int unsigned MAX_DECIMALS_DEF = 5;
  localparam logic [BYTE_W-1:0] RECEIVER_ID_RST = 8'h01;

  // Frame bytes
  localparam logic [BYTE_W-1:0] HEAD_BYTE     = 8'h81;
  localparam logic [BYTE_W-1:0] OP_CONNECT    = 8'h52;
  localparam logic [BYTE_W-1:0] OP_DISCONNECT = 8'h4c;
  localparam logic [BYTE_W-1:0] OP_OFF        = 8'h45;
  localparam logic [BYTE_W-1:0] OP_SET        = 8'h30;
  localparam logic [BYTE_W-1:0] OP_READ       = 8'h3F;
  localparam logic [BYTE_W-1:0] DATA_OFF      = 8'h02;
  localparam logic [BYTE_W-1:0] DATA_SEL_VOLT = 8'hFE;
  localparam logic [BYTE_W-1:0] DATA_SEL_CURR = 8'hFF;

  // Unit codes in the low nibble of the setpoint config byte
  localparam logic [3:0] UNIT_VOLT = 4'h3;
  localparam logic [3:0] UNIT_MA   = 4'h6;
  localparam logic [3:0] UNIT_AMP  = 4'h7;

  // Command kinds
  typedef enum logic [FUNC_W-1:0] {
    FN_CONNECT    = 3'd0,
    FN_DISCONNECT = 3'd1,
    FN_OFF        = 3'd2,
    FN_SET_VOLT   = 3'd3,
    FN_SET_CURR   = 3'd4,
    FN_SEL_VOLT   = 3'd5,
    FN_SEL_CURR   = 3'd6,
    FN_READ       = 3'd7
  } func_e;

  // Operations of the shared BCD shift unit
  typedef enum logic [1:0] {
    BCD_HOLD = 2'd0,
    BCD_LOAD = 2'd1,
    BCD_STEP = 2'd2,
    BCD_SHR  = 2'd3
  } bcd_op_e;

  typedef struct packed {
    bcd_op_e op;
  } bcd_cmd_t;

endpackage

// File: rtl/scfe_bcd_unit.sv
// Shared BCD shift unit: binary-to-BCD by shift-and-add-3, then digit shifts
// right to strip trailing decimal zeros. Controlled by the frame sequencer.
// Depends on scfe_pkg.
module scfe_bcd_unit
  import scfe_pkg::*;
#(
  parameter int unsigned NDIG = BIN_DIGITS
) (
  input  logic                  clk_i,
  input  bcd_cmd_t              cmd_i,
  input  logic [VALUE_W-1:0]    value_i,
  output logic [NDIG*4-1:0]     digits_o,
  output logic                  low_zero_o
);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [NDIG*4-1:0]  bcd_q, bcd_d;
  logic [NDIG*4-1:0]  adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int j = 0; j < NDIG; j++) begin
      if (bcd_q[j*4 +: 4] >= 4'd5) begin
        adj[j*4 +: 4] = bcd_q[j*4 +: 4] + 4'd3;
      end else begin
        adj[j*4 +: 4] = bcd_q[j*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    case (cmd_i.op)
      BCD_LOAD: begin
        bin_d = value_i;
        bcd_d = '0;
      end
      BCD_STEP: begin
        bcd_d = {adj[NDIG*4-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      end
      BCD_SHR: begin
        bcd_d = {4'h0, bcd_q[NDIG*4-1:4]};
      end
      default: begin
        bin_d = bin_q;
        bcd_d = bcd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digits_o   = bcd_q;
  assign low_zero_o = (bcd_q[3:0] == 4'h0);

endmodule

// File: rtl/scfe_framer.sv
// Frame sequencer: takes requests, drives the BCD unit, builds each frame
// byte on the fly with a running XOR checksum and feeds the output register.
// Depends on scfe_pkg.
module scfe_framer
  import scfe_pkg::*;
#(
  parameter int unsigned BCD_DIGITS   = BCD_DIGITS_DEF,
  parameter int unsigned MAX_DECIMALS = MAX_DECIMALS_DEF,
  parameter int unsigned NDIG         = BIN_DIGITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BYTE_W-1:0]   rid_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic                milliamp_i,
  output bcd_cmd_t            cmd_o,
  input  logic [NDIG*4-1:0]   digits_i,
  input  logic                low_zero_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BYTE_W-1:0]   frame_byte_o,
  output logic                last_byte_o
);

  localparam int unsigned BCD_BYTES = (BCD_DIGITS + 1) / 2;
  localparam int unsigned FRAME_MAX = 6 + BCD_BYTES;
  localparam int unsigned IDX_W     = $clog2(FRAME_MAX);
  localparam int unsigned TZ_W      = $clog2(MAX_DECIMALS + 2);
  localparam int unsigned STEP_W    = $clog2(VALUE_W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_TRIM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic                ma_q, ma_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [TZ_W-1:0]     tz_q, tz_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [BYTE_W-1:0]   xor_q, xor_d;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic                last_q, last_d;

  logic                accept;
  logic                load_out;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    data_k;
  logic [BYTE_W-1:0]   cur_byte;
  logic [BYTE_W-1:0]   opcode;
  logic [3:0]          unit;
  logic [3:0]          dec_cnt;

  // Digit j of the trimmed value, zero above the sent digit count
  function automatic logic [3:0] dig(input logic [NDIG*4-1:0] b, input int unsigned j);
    logic [3:0] r;
    r = 4'h0;
    if (j < BCD_DIGITS) begin
      r = b[j*4 +: 4];
    end
    return r;
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign data_k     = idx_q - IDX_W'(4);

  // Opcode and index of the checksum byte per command kind
  always_comb begin
    case (func_q)
      FN_CONNECT:    begin opcode = OP_CONNECT;    last_idx = IDX_W'(4); end
      FN_DISCONNECT: begin opcode = OP_DISCONNECT; last_idx = IDX_W'(4); end
      FN_OFF:        begin opcode = OP_OFF;        last_idx = IDX_W'(5); end
      FN_SET_VOLT:   begin opcode = OP_SET;        last_idx = IDX_W'(FRAME_MAX - 1); end
      FN_SET_CURR:   begin opcode = OP_SET;        last_idx = IDX_W'(FRAME_MAX - 1); end
      FN_SEL_VOLT:   begin opcode = OP_SET;        last_idx = IDX_W'(5); end
      FN_SEL_CURR:   begin opcode = OP_SET;        last_idx = IDX_W'(5); end
      default:       begin opcode = OP_READ;       last_idx = IDX_W'(4); end
    endcase
  end

  // Setpoint config byte pieces
  always_comb begin
    if (func_q == FN_SET_VOLT) begin
      unit = UNIT_VOLT;
    end else if (ma_q) begin
      unit = UNIT_MA;
    end else begin
      unit = UNIT_AMP;
    end
  end
  assign dec_cnt = 4'(MAX_DECIMALS) - 4'(tz_q);

  // Byte at the current frame position
  always_comb begin
    cur_byte = xor_q;
    if (idx_q == '0) begin
      cur_byte = HEAD_BYTE;
    end else if (idx_q == IDX_W'(1)) begin
      cur_byte = BYTE_W'(last_idx) + 8'd1;
    end else if (idx_q == IDX_W'(2)) begin
      cur_byte = rid_i;
    end else if (idx_q == IDX_W'(3)) begin
      cur_byte = opcode;
    end else if (idx_q == last_idx) begin
      cur_byte = xor_q;
    end else begin
      case (func_q)
        FN_OFF:      cur_byte = DATA_OFF;
        FN_SEL_VOLT: cur_byte = DATA_SEL_VOLT;
        FN_SEL_CURR: cur_byte = DATA_SEL_CURR;
        default: begin
          // packed BCD, most significant byte first, then the config byte
          cur_byte = {dec_cnt, unit};
          for (int k = 0; k < BCD_BYTES; k++) begin
            if (data_k == IDX_W'(k)) begin
              cur_byte = {dig(digits_i, 2*(BCD_BYTES-1-k)+1),
                          dig(digits_i, 2*(BCD_BYTES-1-k))};
            end
          end
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    ma_d        = ma_q;
    step_d      = step_q;
    tz_d        = tz_q;
    idx_d       = idx_q;
    xor_d       = xor_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = BCD_HOLD;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d   = func_e'(func_i);
          ma_d     = milliamp_i;
          step_d   = '0;
          tz_d     = '0;
          idx_d    = '0;
          cmd_o.op = BCD_LOAD;
          if ((func_i == FN_SET_VOLT) || (func_i == FN_SET_CURR)) begin
            state_d = ST_CONV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        cmd_o.op = BCD_STEP;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(VALUE_W - 1)) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        // strip trailing decimal zeros up to the decimal limit
        if ((tz_q < TZ_W'(MAX_DECIMALS)) && low_zero_i) begin
          cmd_o.op = BCD_SHR;
          tz_d     = tz_q + TZ_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          byte_d      = cur_byte;
          last_d      = (idx_q == last_idx);
          if (idx_q == '0) begin
            xor_d = '0;
          end else if (idx_q != last_idx) begin
            xor_d = xor_q ^ cur_byte;
          end
          if (idx_q == last_idx) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      tz_q        <= '0;
      idx_q       <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      tz_q        <= tz_d;
      idx_q       <= idx_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    ma_q   <= ma_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

// File: rtl/source_command_frame_encoder_top.sv
// Top level of the source command frame encoder.
// Depends on scfe_pkg, scfe_bcd_unit and scfe_framer.
//
// One request in, one serial command frame out, a byte per output request:
// head 0x81, length, receiver id, opcode, data, XOR checksum (last_byte_o set).
// Commands without a setpoint go from acceptance straight to emitting and
// send 5 or 6 bytes. Setpoint commands first run the shared shift-and-add-3
// unit once per bit of value_e5, then shift out up to MAX_DECIMALS trailing
// zero digits, one per step, with a final step that ends the search, then
// emit 6 + (BCD_DIGITS+1)/2 bytes. in_ready_o is high only between frames;
// it rises as the checksum byte enters the output register. receiver_id
// resets to 1 and is written by cfg_we_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module source_command_frame_encoder_top
  import scfe_pkg::*;
#(
  parameter int unsigned BCD_DIGITS   = BCD_DIGITS_DEF,
  parameter int unsigned MAX_DECIMALS = MAX_DECIMALS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BYTE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [VALUE_W-1:0]  value_e5_i,
  input  logic                milliamp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BYTE_W-1:0]   frame_byte_o,
  output logic                last_byte_o
);

  localparam int unsigned NDIG = (BCD_DIGITS > BIN_DIGITS) ? BCD_DIGITS : BIN_DIGITS;

  logic [BYTE_W-1:0] rid_q;
  bcd_cmd_t          bcd_cmd;
  logic [NDIG*4-1:0] digits;
  logic              low_zero;

  // Receiver id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q <= RECEIVER_ID_RST;
    end else if (cfg_we_i) begin
      rid_q <= cfg_wdata_i;
    end
  end

  scfe_bcd_unit #(
    .NDIG (NDIG)
  ) u_bcd (
    .clk_i      (clk_i),
    .cmd_i      (bcd_cmd),
    .value_i    (value_e5_i),
    .digits_o   (digits),
    .low_zero_o (low_zero)
  );

  scfe_framer #(
    .BCD_DIGITS   (BCD_DIGITS),
    .MAX_DECIMALS (MAX_DECIMALS),
    .NDIG         (NDIG)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rid_i        (rid_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .milliamp_i   (milliamp_i),
    .cmd_o        (bcd_cmd),
    .digits_i     (digits),
    .low_zero_i   (low_zero),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// File: rtl/scfe_checker.sv
// Port-level checker for the source command frame encoder, with its bind.
// Depends on scfe_pkg and source_command_frame_encoder_top.
module scfe_checker
  import scfe_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] frame_byte_o,
  input logic              last_byte_o
);

  // Next output byte opens a frame
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      first_q <= last_byte_o;
    end
  end

  // Stalled output request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(frame_byte_o) && $stable(last_byte_o))
    else $error("output request changed while stalled");

  // Every frame opens with the head byte
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> (frame_byte_o == HEAD_BYTE) && !last_byte_o)
    else $error("frame does not start with head byte");

  // One request at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a request while busy");

  // No new request mid-frame
  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_byte_o |-> !in_ready_o)
    else $error("ready while a frame is still being emitted");

endmodule

bind source_command_frame_encoder_top scfe_checker u_scfe_checker (.*);
